// ===== rtl/core/ppid_pkg.sv =====
// Shared types and constants for the positional PID controller.
package ppid_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 24;
    localparam int ILIM_W     = 23;
    localparam int DLIM_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ENABLE = 3'd5;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 16'd256;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = 16'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 16'd0;
    localparam logic [ILIM_W-1:0] INTEGRAL_LIMIT_RST = 23'h7FFFFF;
    localparam logic [DLIM_W-1:0] DRIVE_LIMIT_RST    = 15'h7FFF;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [ILIM_W-1:0] integral_limit;
        logic [DLIM_W-1:0] drive_limit;
        logic              integral_enable;
    } ppid_cfg_t;

endpackage

// ===== rtl/core/ppid_cfg_regs.sv =====
// Configuration register file for the positional PID controller.
module ppid_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data,
    output ppid_pkg::ppid_cfg_t           cfg
);
    import ppid_pkg::*;

    ppid_cfg_t cfg_reg;
    ppid_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:       cfg_next.prop_gain       = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:      cfg_next.integ_gain      = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:      cfg_next.deriv_gain      = cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT:  cfg_next.integral_limit  = cfg_data[ILIM_W-1:0];
                REG_DRIVE_LIMIT:     cfg_next.drive_limit     = cfg_data[DLIM_W-1:0];
                REG_INTEGRAL_ENABLE: cfg_next.integral_enable = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.integ_gain      <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain      <= DERIV_GAIN_RST;
            cfg_reg.integral_limit  <= INTEGRAL_LIMIT_RST;
            cfg_reg.drive_limit     <= DRIVE_LIMIT_RST;
            cfg_reg.integral_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/positional_pid_controller.sv =====
// Top level of the positional PID controller: input, error, product and output stages.
//
// Usage: each transaction on the s_axis channel carries one measured sample and
// one target sample; each gives exactly one drive transaction on m_axis, in order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// gains, limits and integral enable; it is always ready and should be written
// only while no sample is in flight. Unknown indexes are ignored.
// The path is four register stages: input, error and integral update, the three
// gain multiplies, and the final sum, shift and output clamp. A new sample can be
// taken every cycle while the receiver does not stall; the integral and last-error
// update sits in a single stage, so samples follow each other with no gap.
// When the receiver stalls, each stage holds its item and upstream stages keep
// filling any empty slots, so s_axis_tready drops only once every stage is full.
// Reset clears all stages, the integral and the last error, and loads the
// register defaults (unity proportional gain, full limits, integral on).
module positional_pid_controller
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [15:0] measured, [31:16] target
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [15:0] drive
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppid_pkg::*;

    localparam int PP_W  = GAIN_W + 1 + ERR_W;    // proportional product
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;   // derivative product
    localparam int PI_W  = GAIN_W + 1 + INTEG_W;  // integral product
    localparam int ACC_W = PI_W + 1;
    localparam int SH_W  = ACC_W - 8;

    ppid_cfg_t cfg;

    ppid_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage valids and ready chain.
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_axis_tready = rdy0;
    assign m_axis_tvalid = v3_reg;

    wire adv0 = s_axis_tvalid && rdy0;
    wire adv1 = v0_reg && rdy1;
    wire adv2 = v1_reg && rdy2;
    wire adv3 = v2_reg && rdy3;

    // Stage 0: input samples.
    logic signed [SAMPLE_W-1:0] meas_reg, tgt_reg;

    // Loop state.
    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    logic signed [ERR_W-1:0]   prev_err_reg;

    // Stage 1: error, difference and integral operand.
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [INTEG_W-1:0] iop_reg;

    // Stage 2: products.
    logic signed [PP_W-1:0] pp_reg;
    logic signed [PD_W-1:0] pd_reg;
    logic signed [PI_W-1:0] pi_reg;

    // Stage 3: output.
    logic signed [SAMPLE_W-1:0] drive_reg;

    // Error and integral update.
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic                      opposite;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W:0]   ilim;
    logic signed [INTEG_W-1:0] iop;

    always_comb
    begin
        err  = ERR_W'(tgt_reg) - ERR_W'(meas_reg);
        diff = DIFF_W'(err) - DIFF_W'(prev_err_reg);
        // Zero on either side is not a sign change.
        opposite = (prev_err_reg < 0 && err > 0) || (prev_err_reg > 0 && err < 0);
        ilim = $signed({2'b00, cfg.integral_limit});
        if (opposite)
            isum = (INTEG_W+1)'(err);
        else
            isum = (INTEG_W+1)'(integral_reg) + (INTEG_W+1)'(err);
        priority if (isum > ilim)
            integral_next = ilim[INTEG_W-1:0];
        else if (isum < -ilim)
            integral_next = -ilim[INTEG_W-1:0];
        else
            integral_next = isum[INTEG_W-1:0];
        if (!cfg.integral_enable)
            integral_next = integral_reg;
        iop = cfg.integral_enable ? integral_next : '0;
    end

    // Final sum, floor shift and output clamp.
    logic signed [ACC_W-1:0]    acc;
    logic signed [SH_W-1:0]     shifted;
    logic signed [SH_W-1:0]     dlim;
    logic signed [SAMPLE_W-1:0] drive;

    always_comb
    begin
        acc     = ACC_W'(pp_reg) + ACC_W'(pd_reg) + ACC_W'(pi_reg);
        shifted = acc[ACC_W-1:8];
        dlim    = $signed({{(SH_W-DLIM_W){1'b0}}, cfg.drive_limit});
        priority if (shifted > dlim)
            drive = dlim[SAMPLE_W-1:0];
        else if (shifted < -dlim)
            drive = -dlim[SAMPLE_W-1:0];
        else
            drive = shifted[SAMPLE_W-1:0];
    end

    assign m_axis_tdata = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= s_axis_tvalid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (adv1)
            begin
                integral_reg <= integral_next;
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            meas_reg <= s_axis_tdata[15:0];
            tgt_reg  <= s_axis_tdata[31:16];
        end
        if (adv1)
        begin
            err_reg  <= err;
            diff_reg <= diff;
            iop_reg  <= iop;
        end
        if (adv2)
        begin
            pp_reg <= $signed({1'b0, cfg.prop_gain})  * err_reg;
            pd_reg <= $signed({1'b0, cfg.deriv_gain}) * diff_reg;
            pi_reg <= $signed({1'b0, cfg.integ_gain}) * iop_reg;
        end
        if (adv3)
            drive_reg <= drive;
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking stream testbench for the positional PID controller.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppid_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int GAP_PCT = 23;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] target;
        logic [SAMPLE_W-1:0] measured;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;    // [15:0] measured, [31:16] target
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;         // [15:0] drive
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [GAIN_W-1:0] prop_gain_q = PROP_GAIN_RST;
    logic [GAIN_W-1:0] integ_gain_q = INTEG_GAIN_RST;
    logic [GAIN_W-1:0] deriv_gain_q = DERIV_GAIN_RST;
    logic [ILIM_W-1:0] integral_limit_q = INTEGRAL_LIMIT_RST;
    logic [DLIM_W-1:0] drive_limit_q = DRIVE_LIMIT_RST;
    logic              integral_enable_q = 1'b1;

    // Controller state as the predictor tracks it.
    longint integral_acc = 0;
    longint held_error = 0;

    sample_t     pending_samples[$];
    logic [15:0] expected_drive[$];

    int send_gap_pct = GAP_PCT;
    int ready_gap_pct = GAP_PCT;
    int cycle_count = 0;
    int mismatch_count = 0;
    int samples_sent = 0;
    int drives_checked = 0;
    int reg_writes = 0;

    positional_pid_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint clamp_mag(input longint value, input longint bound);
        if (value > bound)
        begin
            return bound;
        end
        if (value < -bound)
        begin
            return -bound;
        end
        return value;
    endfunction

    // Runs one sample through the controller state and returns the drive it yields.
    function automatic logic [15:0] advance_pid(input logic signed [SAMPLE_W-1:0] meas,
                                                input logic signed [SAMPLE_W-1:0] tgt);
        longint err;
        longint acc;
        bit     flipped;
        err = longint'(tgt) - longint'(meas);
        if (integral_enable_q)
        begin
            flipped = (held_error < 0 && err > 0) || (held_error > 0 && err < 0);
            if (flipped)
            begin
                integral_acc = 0;
            end
            integral_acc = clamp_mag(integral_acc + err, longint'(integral_limit_q));
        end
        acc = longint'(prop_gain_q) * err + longint'(deriv_gain_q) * (err - held_error);
        if (integral_enable_q)
        begin
            acc += longint'(integ_gain_q) * integral_acc;
        end
        // An arithmetic shift of a signed value rounds toward minus infinity.
        acc = clamp_mag(acc >>> 8, longint'(drive_limit_q));
        held_error = err;
        return acc[15:0];
    endfunction

    // Sample driver: loads the next pending sample, with random gaps, when the slot is free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_drive.push_back(advance_pid(s_axis_tdata[15:0], s_axis_tdata[31:16]));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    s_axis_tdata <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Drive monitor: random backpressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $display("%0t: unexpected drive transaction, expected none, actual %0d",
                             $time, $signed(m_axis_tdata));
                    mismatch_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    drives_checked++;
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= ready_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PROP_GAIN:       prop_gain_q = data[GAIN_W-1:0];
            REG_INTEG_GAIN:      integ_gain_q = data[GAIN_W-1:0];
            REG_DERIV_GAIN:      deriv_gain_q = data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT:  integral_limit_q = data[ILIM_W-1:0];
            REG_DRIVE_LIMIT:     drive_limit_q = data[DLIM_W-1:0];
            REG_INTEGRAL_ENABLE: integral_enable_q = data[0];
            default:             ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input int meas, input int tgt);
        sample_t item;
        item.measured = meas[15:0];
        item.target = tgt[15:0];
        pending_samples.push_back(item);
    endtask

    // Waits until every queued sample has been sent and every drive has come back.
    task automatic drain();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_drive.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        if ($urandom_range(99) < 80)
        begin
            return GAIN_W'($urandom_range(1024));
        end
        return GAIN_W'($urandom());
    endfunction

    task automatic randomize_config(input bit allow_disable);
        logic [CFG_DATA_W-1:0] junk;
        logic [ILIM_W-1:0]     ilim;
        junk = CFG_DATA_W'($urandom());
        case ($urandom_range(2))
            0:       ilim = ILIM_W'($urandom_range(2000));
            1:       ilim = ILIM_W'($urandom_range(100000));
            default: ilim = ILIM_W'($urandom());
        endcase
        // Bits above each register's width are random and must be dropped.
        write_reg(REG_PROP_GAIN, {junk[22:16], pick_gain()});
        write_reg(REG_INTEG_GAIN, {junk[21:15], pick_gain()});
        write_reg(REG_DERIV_GAIN, {junk[20:14], pick_gain()});
        write_reg(REG_INTEGRAL_LIMIT, ilim);
        if ($urandom_range(1))
        begin
            write_reg(REG_DRIVE_LIMIT, {junk[22:15], DLIM_W'($urandom())});
        end
        else
        begin
            write_reg(REG_DRIVE_LIMIT, {junk[22:15], DRIVE_LIMIT_RST});
        end
        write_reg(REG_INTEGRAL_ENABLE,
                  {junk[22:1], (!allow_disable || $urandom_range(3) != 0)});
        if ($urandom_range(1))
        begin
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom()));
        end
    endtask

    // Mostly runs of same-sign error around a fixed target, so the integral
    // builds up and is then cleared; the rest is unrelated noise.
    task automatic queue_control_runs(input int count);
        int     left;
        int     run_len;
        int     mag;
        bit     negative;
        int     tgt;
        longint meas;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(99) < 20)
            begin
                queue_sample($urandom(), $urandom());
                left--;
            end
            else
            begin
                run_len = $urandom_range(12, 2);
                tgt = $signed(16'($urandom()));
                negative = $urandom_range(1);
                for (int k = 0; k < run_len && left > 0; k++)
                begin
                    case ($urandom_range(19))
                        0, 1, 2:  mag = $urandom_range(65535);
                        3:        mag = 0;
                        4, 5, 6, 7, 8, 9, 10: mag = $urandom_range(2000);
                        default:  mag = $urandom_range(64);
                    endcase
                    meas = longint'(tgt) - (negative ? -mag : mag);
                    meas = clamp_mag(meas + 1, 32768) - 1;
                    queue_sample(int'(meas), tgt);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: unity proportional gain, full range errors.
        queue_sample(0, 0);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(100, -100);
        queue_sample(-1, 0);
        drain();

        // Integral only: accumulate into the limit, then zero error and sign flips.
        write_reg(REG_PROP_GAIN, '0);
        write_reg(REG_INTEG_GAIN, 23'd256);
        write_reg(REG_INTEGRAL_LIMIT, 23'd1000);
        queue_sample(0, 600);
        queue_sample(0, 600);
        queue_sample(0, 0);
        queue_sample(5, 0);
        queue_sample(0, 3);
        queue_sample(0, 600);
        queue_sample(0, 600);
        drain();

        // Disabled integral keeps its value; a lower limit applies on re-enable.
        write_reg(REG_INTEGRAL_ENABLE, '0);
        queue_sample(0, 400);
        queue_sample(0, 400);
        drain();
        write_reg(REG_INTEGRAL_LIMIT, 23'd100);
        write_reg(REG_INTEGRAL_ENABLE, 23'd1);
        queue_sample(0, 10);
        queue_sample(0, -7);
        drain();

        // Largest gains against a zero output limit, then a zero integral limit.
        write_reg(REG_PROP_GAIN, 23'h7FFFFF);
        write_reg(REG_INTEG_GAIN, 23'h7FFFFF);
        write_reg(REG_DERIV_GAIN, 23'h7FFFFF);
        write_reg(REG_INTEGRAL_LIMIT, 23'h7FFFFF);
        write_reg(REG_DRIVE_LIMIT, 23'h7F8000);
        write_reg(REG_SPARE_LO, 23'h7FFFFF);
        write_reg(REG_SPARE_HI, '0);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        drain();
        write_reg(REG_DRIVE_LIMIT, 23'h7FFF);
        write_reg(REG_INTEGRAL_LIMIT, '0);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(1, 0);
        queue_sample(0, 0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            randomize_config(phase != 0);
            send_gap_pct = (phase == 2) ? 0 : GAP_PCT;
            ready_gap_pct = (phase == 2) ? 0 : GAP_PCT;
            queue_control_runs(25);
            // The sender holds off here until every drive is back.
            drain();
            queue_control_runs(25);
            drain();
        end

        $display("Sent %0d samples, checked %0d drives, made %0d register writes.",
                 samples_sent, drives_checked, reg_writes);
        $display("Covered reset defaults, sign flips, disabled integral, zero and full limits.");
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== positional_pid_controller.f =====
rtl/core/ppid_pkg.sv
rtl/core/ppid_cfg_regs.sv
rtl/core/positional_pid_controller.sv
test/testbench.sv
